### rtl/core/cnls_pkg.sv
// Package: types, codes and nibble tables for the character display nibble sequencer.
package cnls_pkg;

   // Request modes
   localparam logic [2:0] MODE_INIT      = 3'd0;
   localparam logic [2:0] MODE_COMMAND   = 3'd1;
   localparam logic [2:0] MODE_DATA      = 3'd2;
   localparam logic [2:0] MODE_SET_CURSOR = 3'd3;
   localparam logic [2:0] MODE_CLEAR_ROW = 3'd4;

   // Register select levels
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // Last nibble index per job kind
   localparam logic [5:0] LAST_IDX_BYTE  = 6'd1;
   localparam logic [5:0] LAST_IDX_INIT  = 6'd11;
   localparam logic [5:0] LAST_IDX_CLEAR = 6'd39;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] byte_value;
      logic       cursor_row;
      logic [5:0] cursor_col;
   } req_word_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic       register_select;
      logic       last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_INIT,
      JOB_CLEAR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_value;
      logic         rs;
   } job_type;

   // Set DDRAM address command: 0x80 | (row base + column), row base 0x40 for bottom line.
   function automatic logic [7:0] cursor_cmd(input logic row, input logic [5:0] col);
      cursor_cmd = {1'b1, row, col};
   endfunction

   function automatic logic [5:0] last_idx(input job_kind_type kind);
      case (kind)
         JOB_BYTE:  last_idx = LAST_IDX_BYTE;
         JOB_INIT:  last_idx = LAST_IDX_INIT;
         JOB_CLEAR: last_idx = LAST_IDX_CLEAR;
         default:   last_idx = LAST_IDX_BYTE;
      endcase
   endfunction

   // Init run: reset nibbles 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06.
   function automatic logic [3:0] init_nibble(input logic [5:0] idx);
      case (idx)
         6'd0:    init_nibble = 4'h3;
         6'd1:    init_nibble = 4'h3;
         6'd2:    init_nibble = 4'h3;
         6'd3:    init_nibble = 4'h2;
         6'd4:    init_nibble = 4'h2;
         6'd5:    init_nibble = 4'h8;
         6'd6:    init_nibble = 4'h0;
         6'd7:    init_nibble = 4'hC;
         6'd8:    init_nibble = 4'h0;
         6'd9:    init_nibble = 4'h1;
         6'd10:   init_nibble = 4'h0;
         6'd11:   init_nibble = 4'h6;
         default: init_nibble = 4'h0;
      endcase
   endfunction

   function automatic rsp_word_type nibble_of(input job_type job, input logic [5:0] idx);
      rsp_word_type w;
      w.last = (idx == last_idx(job.kind));
      case (job.kind)
         JOB_BYTE: begin
            w.nibble          = idx[0] ? job.byte_value[3:0] : job.byte_value[7:4];
            w.register_select = job.rs;
         end
         JOB_INIT: begin
            w.nibble          = init_nibble(idx);
            w.register_select = RS_INSTR;
         end
         JOB_CLEAR: begin
            if (idx < 6'd2) begin
               w.nibble          = idx[0] ? job.byte_value[3:0] : job.byte_value[7:4];
               w.register_select = RS_INSTR;
            end else begin
               w.nibble          = idx[0] ? SPACE_CHAR[3:0] : SPACE_CHAR[7:4];
               w.register_select = RS_DATA;
            end
         end
         default: begin
            w.nibble          = 4'h0;
            w.register_select = RS_INSTR;
         end
      endcase
      nibble_of = w;
   endfunction

endpackage

### rtl/core/char_lcd_nibble_sequencer_core.sv
// Top level: character display 4-bit bus nibble sequencer.
// Each request word becomes a run of nibble words for a 4-bit character display bus
// (high nibble first, then low nibble; register_select 0 for instructions, 1 for data;
// last marks the final nibble of a request). Modes: init sends 3,3,3,2 then commands
// 0x28, 0x0C, 0x01, 0x06 (12 nibbles); command and data send one byte (2 nibbles);
// set cursor sends 0x80 | (row ? 0x40 : 0) + column (2 nibbles); clear row sends the
// set cursor command for column 0 and then 19 spaces as data (40 nibbles). Modes 5 to 7
// are accepted and produce nothing. Rate: the back-end sequencer emits one nibble word
// per cycle while rsp_stall is low, with no gap between queued requests. Requests land
// in a small job queue (QUEUE_DEPTH entries), so the front end keeps taking requests
// while the back end works and while a result word waits on rsp_stall, until the queue
// is full. A request's first nibble passes through the job queue, the sequencer's job
// register and the output register. No configuration registers, no state between
// requests.
module char_lcd_nibble_sequencer_core #(
   parameter int QUEUE_DEPTH = cnls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cnls_pkg::req_word_type req_word,
   // nibble channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cnls_pkg::rsp_word_type rsp_word
);

   logic              queue_full;
   logic              push_valid;
   cnls_pkg::job_type push_job;
   logic              pop;
   logic              pop_valid;
   cnls_pkg::job_type pop_job;

   // classify requests into jobs
   cnls_front u_front (
      .req_valid  (req_valid),
      .req_word   (req_word),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // decouple front from back
   cnls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   // expand jobs into nibble words
   cnls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### rtl/core/cnls_front.sv
// Front end: takes requests and turns them into sequencer jobs.
module cnls_front (
   input  logic                  req_valid,
   input  cnls_pkg::req_word_type req_word,
   input  logic                  queue_full,
   output logic                  req_stall,
   output logic                  push_valid,
   output cnls_pkg::job_type     push_job
);

   logic mode_ok;

   assign req_stall = queue_full;

   always_comb begin
      mode_ok             = 1'b1;
      push_job.kind       = cnls_pkg::JOB_BYTE;
      push_job.byte_value = req_word.byte_value;
      push_job.rs         = cnls_pkg::RS_INSTR;
      case (req_word.mode)
         cnls_pkg::MODE_INIT: begin
            push_job.kind = cnls_pkg::JOB_INIT;
         end
         cnls_pkg::MODE_COMMAND: begin
            push_job.kind = cnls_pkg::JOB_BYTE;
         end
         cnls_pkg::MODE_DATA: begin
            push_job.rs = cnls_pkg::RS_DATA;
         end
         cnls_pkg::MODE_SET_CURSOR: begin
            push_job.byte_value = cnls_pkg::cursor_cmd(req_word.cursor_row,
                                                       req_word.cursor_col);
         end
         cnls_pkg::MODE_CLEAR_ROW: begin
            push_job.kind       = cnls_pkg::JOB_CLEAR;
            push_job.byte_value = cnls_pkg::cursor_cmd(req_word.cursor_row, 6'd0);
         end
         default: begin
            mode_ok = 1'b0;  // undefined modes are swallowed
         end
      endcase
   end

   assign push_valid = req_valid && !queue_full && mode_ok;

endmodule

### rtl/core/cnls_queue.sv
// Job queue between front end and sequencer.
module cnls_queue #(
   parameter int DEPTH = cnls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cnls_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output cnls_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   cnls_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("job queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count out of range");

endmodule

### rtl/core/cnls_back.sv
// Back end: expands jobs into registered nibble words, one per cycle unless stalled.
module cnls_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  cnls_pkg::job_type      job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cnls_pkg::rsp_word_type rsp_word
);

   logic                   busy_ff, busy_in;
   cnls_pkg::job_type      job_ff, job_in;
   logic [5:0]             idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cnls_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   cnls_pkg::rsp_word_type cur;
   logic                   out_free;
   logic                   advance;
   logic                   finish;

   assign cur      = cnls_pkg::nibble_of(job_ff, idx_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;
   assign finish   = advance && cur.last;
   assign job_pop  = job_valid && (!busy_ff || finish);

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         idx_in       = idx_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_word_in  = cur;
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = job;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= cnls_pkg::last_idx(job_ff.kind)))
      else $error("nibble index past end of job");

   a_stay_busy: assert property (@(posedge clock) disable iff (reset)
      (advance && !cur.last) |=> busy_ff)
      else $error("sequencer dropped a job before its last nibble");

endmodule

### tb/tb.sv
// Testbench for the character display nibble sequencer: directed table, random phases, checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int DIRECTED_ROWS = 20;
   localparam int PHASE_ITEMS   = 78;   // counted random requests per phase
   localparam int DRAIN_CYCLES  = 20;   // settle time after the last nibble
   localparam int STALL_LIMIT   = 2000; // cycles with no word moving on either side
   localparam int REPORT_LIMIT  = 10;

   // modes the block takes and drops silently
   localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] MODE_RESERVED_MID   = 3'd6;
   localparam logic [2:0] MODE_RESERVED_LAST  = 3'd7;

   // display protocol constants
   localparam logic [3:0] NIB_RESET       = 4'h3; // 8-bit reset nibble
   localparam logic [3:0] NIB_FOUR_BIT    = 4'h2; // switch to 4-bit bus
   localparam logic [7:0] CMD_FUNCTION    = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
   localparam logic [7:0] BOTTOM_BASE     = 8'h40;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam int         ROW_SPACES      = 19;
   localparam int         RESET_NIBBLES   = 3;

   // how a directed row gets its expected nibbles
   typedef enum logic [1:0] {
      EXP_PREDICTED,  // from the predictor
      EXP_TYPED_BYTE, // one byte typed into the table
      EXP_NONE        // dropped request, nothing comes out
   } expect_kind_type;

   typedef struct packed {
      cnls_pkg::req_word_type word;
      expect_kind_type        kind;
      logic [7:0]             byte_value;
      logic                   rs;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   cnls_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   cnls_pkg::rsp_word_type rsp_word;

   // side info that travels with the request word, read at acceptance
   expect_kind_type word_kind = EXP_PREDICTED;
   logic [7:0]      word_byte = 8'h00;
   logic            word_rs   = 1'b0;

   cnls_pkg::rsp_word_type pending_nibbles [$];
   int           error_count     = 0;
   int           nibbles_checked = 0;
   int           requests_by_mode [8];
   int           idle_cycles     = 0;
   int           sender_idle_pct = 0;
   int           stall_pct       = 0;

   char_lcd_nibble_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: expands one request word into its nibble words
   // ---------------------------------------------------------------
   function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
                                        input logic is_last);
      cnls_pkg::rsp_word_type w;
      w.nibble          = nib;
      w.register_select = rs;
      w.last            = is_last;
      pending_nibbles.push_back(w);
   endfunction

   // high nibble first; only the low nibble can close a request
   function automatic void queue_byte(input logic [7:0] b, input logic rs,
                                      input logic is_last);
      queue_nibble(b[7:4], rs, 1'b0);
      queue_nibble(b[3:0], rs, is_last);
   endfunction

   // set DDRAM address: line base plus column, never wraps past 0x7F
   function automatic logic [7:0] cursor_address_cmd(input logic row, input logic [5:0] col);
      logic [7:0] base;
      base = row ? BOTTOM_BASE : 8'h00;
      cursor_address_cmd = CMD_SET_ADDRESS | (base + {2'b00, col});
   endfunction

   function automatic void expand_request(input cnls_pkg::req_word_type w);
      case (w.mode)
         cnls_pkg::MODE_INIT: begin
            for (int i = 0; i < RESET_NIBBLES; i++)
               queue_nibble(NIB_RESET, cnls_pkg::RS_INSTR, 1'b0);
            queue_nibble(NIB_FOUR_BIT, cnls_pkg::RS_INSTR, 1'b0);
            queue_byte(CMD_FUNCTION, cnls_pkg::RS_INSTR, 1'b0);
            queue_byte(CMD_DISPLAY_ON, cnls_pkg::RS_INSTR, 1'b0);
            queue_byte(CMD_CLEAR, cnls_pkg::RS_INSTR, 1'b0);
            queue_byte(CMD_ENTRY_MODE, cnls_pkg::RS_INSTR, 1'b1);
         end
         cnls_pkg::MODE_COMMAND:    queue_byte(w.byte_value, cnls_pkg::RS_INSTR, 1'b1);
         cnls_pkg::MODE_DATA:       queue_byte(w.byte_value, cnls_pkg::RS_DATA, 1'b1);
         cnls_pkg::MODE_SET_CURSOR: queue_byte(cursor_address_cmd(w.cursor_row, w.cursor_col),
                                               cnls_pkg::RS_INSTR, 1'b1);
         cnls_pkg::MODE_CLEAR_ROW: begin
            // home the cursor on that line, then blank it
            queue_byte(cursor_address_cmd(w.cursor_row, 6'd0), cnls_pkg::RS_INSTR, 1'b0);
            for (int i = 0; i < ROW_SPACES; i++)
               queue_byte(CHAR_SPACE, cnls_pkg::RS_DATA, i == ROW_SPACES - 1);
         end
         default: ; // reserved modes: nothing
      endcase
   endfunction

   function automatic stim_row_type make_row(input logic [2:0] mode, input logic [7:0] b,
                                             input logic row, input logic [5:0] col,
                                             input expect_kind_type kind,
                                             input logic [7:0] exp_byte, input logic exp_rs);
      stim_row_type r;
      r.word.mode       = mode;
      r.word.byte_value = b;
      r.word.cursor_row = row;
      r.word.cursor_col = col;
      r.kind            = kind;
      r.byte_value      = exp_byte;
      r.rs              = exp_rs;
      make_row = r;
   endfunction

   task automatic note_failure(input string what, input cnls_pkg::rsp_word_type exp_w,
                               input cnls_pkg::rsp_word_type act_w);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("tb: %s at %0t: expected nibble %h rs %b last %b, got nibble %h rs %b last %b",
                  what, $realtime, exp_w.nibble, exp_w.register_select, exp_w.last,
                  act_w.nibble, act_w.register_select, act_w.last);
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ---------------------------------------------------------------
   // Monitor: checks nibble words, records expectations on request
   // acceptance, and runs the watchdog. One process, so a check and a
   // push in the same cycle always happen in the same order.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      cnls_pkg::rsp_word_type exp_w;
      bit                     progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            nibbles_checked++;
            if (pending_nibbles.size() == 0) begin
               note_failure("nibble with nothing pending", '0, rsp_word);
            end else begin
               exp_w = pending_nibbles.pop_front();
               if (rsp_word.nibble !== exp_w.nibble ||
                   rsp_word.register_select !== exp_w.register_select ||
                   rsp_word.last !== exp_w.last)
                  note_failure("nibble mismatch", exp_w, rsp_word);
            end
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            requests_by_mode[req_word.mode]++;
            case (word_kind)
               EXP_PREDICTED:  expand_request(req_word);
               EXP_TYPED_BYTE: queue_byte(word_byte, word_rs, 1'b1);
               default: ;      // EXP_NONE
            endcase
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("tb: watchdog, no word moved for %0d cycles", STALL_LIMIT);
               $display("tb: errors");
               $finish;
            end
         end
      end
   end

   // Present one request word and hold it until accepted, then maybe idle.
   // Valid stays high into the next word when no gap is drawn.
   task automatic send_word(input cnls_pkg::req_word_type w, input expect_kind_type kind,
                            input logic [7:0] exp_byte, input logic exp_rs);
      req_word  <= w;
      word_kind <= kind;
      word_byte <= exp_byte;
      word_rs   <= exp_rs;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Stop sending until every pending nibble has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_nibbles.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      stim_row_type           directed_rows [DIRECTED_ROWS];
      cnls_pkg::req_word_type w;
      int                     counted;
      int                     pick;

      for (int m = 0; m < 8; m++)
         requests_by_mode[m] = 0;

      // extremes, every mode, ignored fields, dropped modes
      directed_rows[0]  = make_row(cnls_pkg::MODE_INIT, 8'h00, 1'b0, 6'd0,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[1]  = make_row(cnls_pkg::MODE_COMMAND, 8'h00, 1'b0, 6'd0,
                                   EXP_TYPED_BYTE, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[2]  = make_row(cnls_pkg::MODE_COMMAND, 8'hFF, 1'b1, 6'd63,
                                   EXP_TYPED_BYTE, 8'hFF, cnls_pkg::RS_INSTR);
      directed_rows[3]  = make_row(cnls_pkg::MODE_DATA, 8'h00, 1'b0, 6'd0,
                                   EXP_TYPED_BYTE, 8'h00, cnls_pkg::RS_DATA);
      directed_rows[4]  = make_row(cnls_pkg::MODE_DATA, 8'hFF, 1'b0, 6'd0,
                                   EXP_TYPED_BYTE, 8'hFF, cnls_pkg::RS_DATA);
      directed_rows[5]  = make_row(cnls_pkg::MODE_DATA, 8'hA5, 1'b1, 6'd63,
                                   EXP_TYPED_BYTE, 8'hA5, cnls_pkg::RS_DATA);
      directed_rows[6]  = make_row(cnls_pkg::MODE_SET_CURSOR, 8'h00, 1'b0, 6'd0,
                                   EXP_TYPED_BYTE, 8'h80, cnls_pkg::RS_INSTR);
      directed_rows[7]  = make_row(cnls_pkg::MODE_SET_CURSOR, 8'h00, 1'b0, 6'd63,
                                   EXP_TYPED_BYTE, 8'hBF, cnls_pkg::RS_INSTR);
      directed_rows[8]  = make_row(cnls_pkg::MODE_SET_CURSOR, 8'h00, 1'b1, 6'd0,
                                   EXP_TYPED_BYTE, 8'hC0, cnls_pkg::RS_INSTR);
      directed_rows[9]  = make_row(cnls_pkg::MODE_SET_CURSOR, 8'hFF, 1'b1, 6'd63,
                                   EXP_TYPED_BYTE, 8'hFF, cnls_pkg::RS_INSTR);
      directed_rows[10] = make_row(cnls_pkg::MODE_SET_CURSOR, 8'h5A, 1'b1, 6'd42,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[11] = make_row(cnls_pkg::MODE_CLEAR_ROW, 8'h00, 1'b0, 6'd0,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[12] = make_row(cnls_pkg::MODE_CLEAR_ROW, 8'hFF, 1'b1, 6'd63,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[13] = make_row(MODE_RESERVED_FIRST, 8'h00, 1'b0, 6'd0,
                                   EXP_NONE, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[14] = make_row(MODE_RESERVED_MID, 8'hFF, 1'b1, 6'd63,
                                   EXP_NONE, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[15] = make_row(MODE_RESERVED_LAST, 8'h3C, 1'b0, 6'd21,
                                   EXP_NONE, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[16] = make_row(cnls_pkg::MODE_COMMAND, 8'h5A, 1'b0, 6'd21,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[17] = make_row(cnls_pkg::MODE_DATA, 8'h3C, 1'b1, 6'd42,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[18] = make_row(cnls_pkg::MODE_INIT, 8'hFF, 1'b1, 6'd63,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
      directed_rows[19] = make_row(cnls_pkg::MODE_CLEAR_ROW, 8'h81, 1'b0, 6'd21,
                                   EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words, back to back
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(directed_rows[i].word, directed_rows[i].kind,
                   directed_rows[i].byte_value, directed_rows[i].rs);
      wait_for_drain();

      // random phases: free run, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 72; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 72; end
            default: begin sender_idle_pct = 28; stall_pct = 28; end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            w.byte_value = 8'($urandom_range(255));
            w.cursor_row = 1'($urandom_range(1));
            w.cursor_col = 6'($urandom_range(63));
            // mostly two-nibble requests, some long runs, a few dropped modes
            if (pick < 4)
               w.mode = 3'($urandom_range(MODE_RESERVED_LAST, MODE_RESERVED_FIRST));
            else if (pick < 10)
               w.mode = cnls_pkg::MODE_INIT;
            else if (pick < 18)
               w.mode = cnls_pkg::MODE_CLEAR_ROW;
            else
               w.mode = 3'($urandom_range(cnls_pkg::MODE_SET_CURSOR, cnls_pkg::MODE_COMMAND));
            send_word(w, EXP_PREDICTED, 8'h00, cnls_pkg::RS_INSTR);
            if (w.mode <= cnls_pkg::MODE_CLEAR_ROW)
               counted++;
         end
         // hold the sender until the block has emptied out
         wait_for_drain();
      end

      sender_idle_pct = 0;
      stall_pct       = 0;
      while (pending_nibbles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d init, %0d command, %0d data, %0d cursor, %0d clear row, %0d dropped",
               requests_by_mode[cnls_pkg::MODE_INIT], requests_by_mode[cnls_pkg::MODE_COMMAND],
               requests_by_mode[cnls_pkg::MODE_DATA],
               requests_by_mode[cnls_pkg::MODE_SET_CURSOR],
               requests_by_mode[cnls_pkg::MODE_CLEAR_ROW],
               requests_by_mode[MODE_RESERVED_FIRST] + requests_by_mode[MODE_RESERVED_MID] +
               requests_by_mode[MODE_RESERVED_LAST]);
      $display("tb: %0d nibble words checked over four gap/stall phases, %0d mismatches",
               nibbles_checked, error_count);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
